FILE: src/utf8_identity_validator_core_defines.svh
// Assertion macros shared by the validator RTL.
`ifndef UTF8_IDENTITY_VALIDATOR_CORE_DEFINES_SVH
`define UTF8_IDENTITY_VALIDATOR_CORE_DEFINES_SVH

// cons must hold at every edge out of reset at which ante holds
`define UIV_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 validator: check failed");

// cons must hold in the cycle after ante
`define UIV_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 validator: check failed");

`endif

FILE: src/utf8iv_pkg.sv
`default_nettype none

package utf8iv_pkg;

  localparam int MAX_LEN_W  = 13;
  localparam int BYTE_LEN_W = 13;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 13'd256;

  typedef enum logic [2:0] {
    FLT_OK,
    FLT_EMPTY,
    FLT_TOO_LONG,
    FLT_BAD_LEAD,
    FLT_TRUNCATED,
    FLT_BAD_SECOND,
    FLT_BAD_CONT,
    FLT_CONTROL
  } fault_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic                  valid_res;
    fault_t                fault;
    logic [BYTE_LEN_W-1:0] byte_length;
  } verdict_t;

endpackage

`default_nettype wire

FILE: src/utf8iv_in_reg.sv
`default_nettype none

module utf8iv_in_reg
  import utf8iv_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_tvalid,
  output logic  in_tready,
  input  item_t in_item,
  input  wire   advance,
  output logic  stage_valid,
  output item_t stage_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

`default_nettype wire

FILE: src/utf8iv_check.sv
`default_nettype none

`include "utf8_identity_validator_core_defines.svh"

module utf8iv_check
  import utf8iv_pkg::*;
#(
  parameter int COUNT_LIMIT = 4096
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  item_t                item,
  input  wire  [MAX_LEN_W-1:0] max_length,
  output verdict_t             verdict
);

  localparam int CNT_W = $clog2(COUNT_LIMIT + 2);
  localparam int CMP_W = (CNT_W > BYTE_LEN_W) ? CNT_W : BYTE_LEN_W;

  localparam logic [7:0] ASCII_HI = 8'h7f;
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;
  localparam logic [7:0] LEAD_SURR = 8'hed;
  localparam logic [7:0] E0_MIN   = 8'ha0;
  localparam logic [7:0] ED_LIM   = 8'ha0;
  localparam logic [7:0] F0_MIN   = 8'h90;
  localparam logic [7:0] F4_MAX   = 8'h8f;

  logic [1:0]       pend_r, pend_nxt;
  logic [7:0]       lead_r, lead_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic [20:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  fault_t           ff_r, ff_nxt;

  logic [7:0]       b;
  logic             range_bad;
  logic [CMP_W-1:0] cnt_ext, ml_ext, cl_ext, lim_ext;
  fault_t           fault;

  function automatic logic is_control(input logic [20:0] cp);
    return (cp < 21'h20) || (cp >= 21'h7f && cp <= 21'h9f);
  endfunction

  assign b = item.data_byte;

  assign range_bad = (pos_r == 2'd0) &&
                     ((lead_r == LEAD3_LO  && b < E0_MIN) ||
                      (lead_r == LEAD_SURR && b >= ED_LIM) ||
                      (lead_r == LEAD4_LO  && b < F0_MIN) ||
                      (lead_r == LEAD4_HI  && b > F4_MAX));

  always_comb begin
    pend_nxt = pend_r;
    lead_nxt = lead_r;
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ff_nxt   = ff_r;
    if (item.has_byte && cnt_r <= CNT_W'(COUNT_LIMIT)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (item.has_byte && ff_r == FLT_OK) begin
      if (pend_r == 2'd0) begin
        lead_nxt = b;
        pos_nxt  = 2'd0;
        unique case (b) inside
          [8'h00:ASCII_HI]: begin
            acc_nxt = {13'd0, b};
            if (is_control(acc_nxt)) begin
              ff_nxt = FLT_CONTROL;
            end
          end
          [LEAD2_LO:LEAD2_HI]: begin
            pend_nxt = 2'd1;
            acc_nxt  = {16'd0, b[4:0]};
          end
          [LEAD3_LO:LEAD3_HI]: begin
            pend_nxt = 2'd2;
            acc_nxt  = {17'd0, b[3:0]};
          end
          [LEAD4_LO:LEAD4_HI]: begin
            pend_nxt = 2'd3;
            acc_nxt  = {18'd0, b[2:0]};
          end
          default: begin
            ff_nxt = FLT_BAD_LEAD;
          end
        endcase
      end else if (range_bad) begin
        ff_nxt = FLT_BAD_SECOND;
      end else if (b[7:6] != 2'b10) begin
        ff_nxt = FLT_BAD_CONT;
      end else begin
        acc_nxt  = {acc_r[14:0], b[5:0]};
        pos_nxt  = pos_r + 2'd1;
        pend_nxt = pend_r - 2'd1;
        if (pend_nxt == 2'd0 && is_control(acc_nxt)) begin
          ff_nxt = FLT_CONTROL;
        end
      end
    end
  end

  assign cnt_ext = CMP_W'(cnt_nxt);
  assign ml_ext  = CMP_W'(max_length);
  assign cl_ext  = CMP_W'(COUNT_LIMIT);
  assign lim_ext = (ml_ext > cl_ext) ? cl_ext : ml_ext;

  always_comb begin
    if (cnt_ext == '0) begin
      fault = FLT_EMPTY;
    end else if (cnt_ext > lim_ext) begin
      fault = FLT_TOO_LONG;
    end else if (ff_nxt != FLT_OK) begin
      fault = ff_nxt;
    end else if (pend_nxt != 2'd0) begin
      fault = FLT_TRUNCATED;
    end else begin
      fault = FLT_OK;
    end
  end

  assign verdict.valid_res   = (fault == FLT_OK);
  assign verdict.fault       = fault;
  assign verdict.byte_length = cnt_ext[BYTE_LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      lead_r <= 8'd0;
      pos_r  <= 2'd0;
      acc_r  <= 21'd0;
      cnt_r  <= '0;
      ff_r   <= FLT_OK;
    end else if (step) begin
      if (item.last) begin
        pend_r <= 2'd0;
        lead_r <= 8'd0;
        pos_r  <= 2'd0;
        acc_r  <= 21'd0;
        cnt_r  <= '0;
        ff_r   <= FLT_OK;
      end else begin
        pend_r <= pend_nxt;
        lead_r <= lead_nxt;
        pos_r  <= pos_nxt;
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        ff_r   <= ff_nxt;
      end
    end
  end

  `UIV_NEXT(a_clear_after_last, step && item.last, cnt_r == '0 && pend_r == 2'd0 && ff_r == FLT_OK)
  `UIV_IMPLIES(a_seq_bound, pend_r != 2'd0, ({1'b0, pos_r} + {1'b0, pend_r}) <= 3'd3)
  `UIV_IMPLIES(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(COUNT_LIMIT + 1))

endmodule

`default_nettype wire

FILE: src/utf8_identity_validator_core.sv
// Strict UTF-8 string validator. Bytes of a string stream in on the in_ channel, one word
// per cycle while no verdict waits, and a single verdict word leaves on the out_ channel
// when the string's last word has been taken. A word is registered on acceptance and
// decoded against the open sequence state in the next cycle; for the word that carries
// tlast the verdict is loaded into the output register at the edge that steps that word
// out of the input register, which sets out_tvalid. Throughput is one word per cycle
// while no verdict waits, set by the single decode-and-length-compare pass between the
// input register and the output register. While a verdict waits on out_tready, a word
// that carries tlast is held in the input register and in_tready stays low until the
// verdict is taken. max_length (cfg_wdata) resets to 256 and is clipped to COUNT_LIMIT.
`default_nettype none

`include "utf8_identity_validator_core_defines.svh"

module utf8_identity_validator_core
  import utf8iv_pkg::*;
#(
  parameter int COUNT_LIMIT = 4096
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire  [MAX_LEN_W-1:0] cfg_wdata,   // max_length
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [7:0]           in_tdata,    // data_byte
  input  wire                  in_tuser,    // has_byte
  input  wire                  in_tlast,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [15:0]          out_tdata,   // fault[2:0], byte_length[15:3]
  output logic                 out_tuser    // valid_res
);

  logic [MAX_LEN_W-1:0] max_length_r;
  item_t                in_item;
  item_t                stage;
  logic                 stage_valid;
  logic                 adv;
  verdict_t             verdict;
  verdict_t             out_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      max_length_r <= cfg_wdata;
    end
  end

  assign in_item.data_byte = in_tdata;
  assign in_item.has_byte  = in_tuser;
  assign in_item.last      = in_tlast;

  assign adv      = stage_valid && (!stage.last || !out_valid_r || out_tready);
  assign load_out = adv && stage.last;

  utf8iv_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_item     (in_item),
    .advance     (adv),
    .stage_valid (stage_valid),
    .stage_item  (stage)
  );

  utf8iv_check #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .item       (stage),
    .max_length (max_length_r),
    .verdict    (verdict)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.byte_length, out_r.fault};
  assign out_tuser  = out_r.valid_res;

  `UIV_IMPLIES(a_valid_matches_fault, out_tvalid, out_tuser == (out_r.fault == FLT_OK))
  `UIV_IMPLIES(a_empty_no_bytes, out_tvalid && out_r.fault == FLT_EMPTY, out_r.byte_length == '0)
  `UIV_IMPLIES(a_no_overwrite, out_valid_r && !out_tready && stage_valid && stage.last, !adv)

endmodule

`default_nettype wire
